// ===== hdl/fog_noise_texel_rgb_macros.svh =====
// assertion macros for the fog noise texel block
// used by the top level, expects clk and rst in scope
`ifndef FOG_NOISE_TEXEL_RGB_MACROS_SVH
`define FOG_NOISE_TEXEL_RGB_MACROS_SVH

// same-cycle implication
`define FNT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fog noise texel: same-cycle check failed");

// next-cycle implication
`define FNT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fog noise texel: next-cycle check failed");

`endif

// ===== hdl/fnt_pkg.sv =====
// shared constants, types and helper functions for the fog noise texel block
// no dependencies
package fnt_pkg;

  localparam int COORD_BITS = 12;
  localparam int OCTAVES    = 4;
  localparam int FRAC_BITS  = 16;

  localparam int DIM_BITS     = 13;
  localparam int DATA_BITS    = 32;
  localparam int CFG_IDX_BITS = 2;
  localparam int COLOR_BITS   = 8;
  localparam int NOISE_BITS   = 24;
  localparam int S_BITS       = 17;
  localparam int QW           = COORD_BITS + FRAC_BITS;
  localparam int CW           = FRAC_BITS + 32;
  localparam int TP_BITS      = DATA_BITS + 16;
  localparam int TS_SHIFT     = 32 - FRAC_BITS;

  localparam int DIV_STEPS  = 4;
  localparam int DIV_STAGES = (QW + DIV_STEPS - 1) / DIV_STEPS;
  localparam int NV_LAT     = 6;
  localparam int MIX_LAT    = 3;
  localparam int PIPE_LAT   = DIV_STAGES + 1 + NV_LAT + MIX_LAT;
  localparam int LANES      = OCTAVES + 2;
  localparam int ACC_W      = 42;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_SEED   = 2'd2,
    REG_TIME   = 2'd3
  } cfg_reg_t;

  localparam logic [DIM_BITS-1:0]  RESET_DIM = 13'd256;
  localparam logic [31:0] HASH_X = 32'd374761393;
  localparam logic [31:0] HASH_Y = 32'd668265263;
  localparam logic [31:0] HASH_S = 32'd362437;
  localparam logic [31:0] MIX_C1 = 32'h7feb352d;
  localparam logic [31:0] MIX_C2 = 32'h846ca68b;

  localparam logic [31:0] SEED_STEP   = 32'd67;
  localparam logic [31:0] SEED_GRAIN  = 32'd1009;
  localparam logic [31:0] SEED_STRIPE = 32'd2203;

  localparam logic [15:0] K_DRIFT_X = 16'd3277;
  localparam logic [15:0] K_DRIFT_Y = 16'd1966;
  localparam logic [15:0] K_STRIPE  = 16'd6554;
  localparam logic [15:0] K_DIAG    = 16'd5243;

  localparam logic [NOISE_BITS-1:0] GLITCH_LEVEL = 24'd12415139;
  localparam logic [15:0] DIAG_LO = 16'd22937;
  localparam logic [15:0] DIAG_HI = 16'd39322;

  localparam logic [15:0] CH_BASE   [3] = '{16'd3277, 16'd14418, 16'd18350};
  localparam logic [15:0] CH_FOG    [3] = '{16'd6554, 16'd29491, 16'd34079};
  localparam logic [15:0] CH_GRAIN  [3] = '{16'd3277, 16'd5243, 16'd5243};
  localparam logic [15:0] CH_GLITCH [3] = '{16'd19661, 16'd1311, 16'd14418};

  typedef struct packed {
    logic [DIM_BITS-1:0]           width;
    logic [DIM_BITS-1:0]           height;
    logic [CW-1:0]                 ts_x;
    logic [CW-1:0]                 ts_y;
    logic [CW-1:0]                 ts_stripe;
    logic [CW-1:0]                 ts_diag;
    logic [CW-1:0]                 dx5;
    logic [CW-1:0]                 dy4;
    logic [OCTAVES-1:0][31:0]      sdp_fog;
    logic [31:0]                   sdp_grain;
    logic [31:0]                   sdp_stripe;
  } cfg_t;

  // fraction to q0.16, truncating or widening
  function automatic logic [15:0] to_q16(input logic [FRAC_BITS-1:0] f);
    logic [FRAC_BITS+15:0] w;
    w = {f, 16'b0};
    return w[FRAC_BITS+15 -: 16];
  endfunction

  function automatic logic [NOISE_BITS-1:0] blend(input logic [NOISE_BITS-1:0] a,
                                                  input logic [NOISE_BITS-1:0] b,
                                                  input logic [S_BITS-1:0] s);
    logic [NOISE_BITS+S_BITS-1:0] acc;
    logic [S_BITS-1:0] sn;
    sn  = S_BITS'(17'h10000) - s;
    acc = (NOISE_BITS+S_BITS)'(a) * (NOISE_BITS+S_BITS)'(sn)
        + (NOISE_BITS+S_BITS)'(b) * (NOISE_BITS+S_BITS)'(s);
    return acc[NOISE_BITS+15:16];
  endfunction

endpackage

// ===== hdl/fnt_config.sv =====
// configuration registers and values derived from them
// depends on fnt_pkg
module fnt_config (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [fnt_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [fnt_pkg::DATA_BITS-1:0]       cfg_data,
  output fnt_pkg::cfg_t                       cfg
);
  import fnt_pkg::*;

  logic [DIM_BITS-1:0]  width_r;
  logic [DIM_BITS-1:0]  height_r;
  logic [DATA_BITS-1:0] seed_r;
  logic [DATA_BITS-1:0] time_r;

  logic [OCTAVES-1:0][31:0] seed_fog;
  logic [31:0]  seed_grain;
  logic [31:0]  seed_stripe;
  logic [TP_BITS-1:0] tp_x;
  logic [TP_BITS-1:0] tp_y;
  logic [TP_BITS-1:0] tp_stripe;
  logic [TP_BITS-1:0] tp_diag;
  cfg_t cfg_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_r  <= RESET_DIM;
      height_r <= RESET_DIM;
      seed_r   <= '0;
      time_r   <= '0;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_WIDTH:  width_r  <= cfg_data[DIM_BITS-1:0];
        REG_HEIGHT: height_r <= cfg_data[DIM_BITS-1:0];
        REG_SEED:   seed_r   <= cfg_data;
        REG_TIME:   time_r   <= cfg_data;
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < OCTAVES; i++) begin
      seed_fog[i] <= seed_r + 32'(i) * SEED_STEP;
    end
    seed_grain  <= seed_r + SEED_GRAIN;
    seed_stripe <= seed_r + SEED_STRIPE;
    tp_x        <= TP_BITS'(time_r) * TP_BITS'(K_DRIFT_X);
    tp_y        <= TP_BITS'(time_r) * TP_BITS'(K_DRIFT_Y);
    tp_stripe   <= TP_BITS'(time_r) * TP_BITS'(K_STRIPE);
    tp_diag     <= TP_BITS'(time_r) * TP_BITS'(K_DIAG);
  end

  always_comb begin
    cfg_next.width     = (width_r == '0) ? DIM_BITS'(1) : width_r;
    cfg_next.height    = (height_r == '0) ? DIM_BITS'(1) : height_r;
    cfg_next.ts_x      = CW'(tp_x >> TS_SHIFT);
    cfg_next.ts_y      = CW'(tp_y >> TS_SHIFT);
    cfg_next.ts_stripe = CW'(tp_stripe >> TS_SHIFT);
    cfg_next.ts_diag   = CW'(tp_diag >> TS_SHIFT);
    cfg_next.dx5       = (cfg_next.ts_x << 2) + cfg_next.ts_x;
    cfg_next.dy4       = cfg_next.ts_y << 2;
    for (int i = 0; i < OCTAVES; i++) begin
      cfg_next.sdp_fog[i] = seed_fog[i] * HASH_S;
    end
    cfg_next.sdp_grain  = seed_grain * HASH_S;
    cfg_next.sdp_stripe = seed_stripe * HASH_S;
  end

  always_ff @(posedge clk) begin
    cfg <= cfg_next;
  end

endmodule

// ===== hdl/fnt_divider.sv =====
// pipelined restoring divider, four (DIV_STEPS) quotient bits per stage
// depends on fnt_pkg
module fnt_divider (
  input  logic                            clk,
  input  logic                            en,
  input  logic [fnt_pkg::QW-1:0]          dividend,
  input  logic [fnt_pkg::DIM_BITS-1:0]    divisor,
  output logic [fnt_pkg::QW-1:0]          quotient
);
  import fnt_pkg::*;

  logic [DIM_BITS-1:0] rem_r [DIV_STAGES];
  logic [QW-1:0]       qn_r  [DIV_STAGES];
  logic [DIM_BITS-1:0] rem_in [DIV_STAGES];
  logic [QW-1:0]       qn_in  [DIV_STAGES];
  logic [DIM_BITS-1:0] rem_next [DIV_STAGES];
  logic [QW-1:0]       qn_next  [DIV_STAGES];

  always_comb begin
    logic [DIM_BITS:0]   trial;
    logic [DIM_BITS-1:0] r;
    logic [QW-1:0]       q;
    rem_in[0] = '0;
    qn_in[0]  = dividend;
    for (int s = 1; s < DIV_STAGES; s++) begin
      rem_in[s] = rem_r[s-1];
      qn_in[s]  = qn_r[s-1];
    end
    for (int s = 0; s < DIV_STAGES; s++) begin
      r = rem_in[s];
      q = qn_in[s];
      for (int k = 0; k < DIV_STEPS; k++) begin
        if (s * DIV_STEPS + k < QW) begin
          trial = {r, q[QW-1]};
          q     = {q[QW-2:0], 1'b0};
          if (trial >= {1'b0, divisor}) begin
            r    = DIM_BITS'(trial - {1'b0, divisor});
            q[0] = 1'b1;
          end else begin
            r = trial[DIM_BITS-1:0];
          end
        end
      end
      rem_next[s] = r;
      qn_next[s]  = q;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < DIV_STAGES; s++) begin
        rem_r[s] <= rem_next[s];
        qn_r[s]  <= qn_next[s];
      end
    end
  end

  assign quotient = qn_r[DIV_STAGES-1];

endmodule

// ===== hdl/fnt_coords.sv =====
// per-lane noise coordinates and diagonal fraction from normalized u, v
// depends on fnt_pkg
module fnt_coords (
  input  logic                                  clk,
  input  logic                                  en,
  input  logic [fnt_pkg::QW-1:0]                u,
  input  logic [fnt_pkg::QW-1:0]                v,
  input  fnt_pkg::cfg_t                         cfg,
  output logic [fnt_pkg::OCTAVES-1:0][fnt_pkg::CW-1:0] fog_x,
  output logic [fnt_pkg::OCTAVES-1:0][fnt_pkg::CW-1:0] fog_y,
  output logic [fnt_pkg::CW-1:0]                grain_x,
  output logic [fnt_pkg::CW-1:0]                grain_y,
  output logic [fnt_pkg::CW-1:0]                stripe_x,
  output logic [fnt_pkg::CW-1:0]                stripe_y,
  output logic [15:0]                           diag
);
  import fnt_pkg::*;

  logic [QW+2:0] u5;
  logic [QW+2:0] v5;
  logic [CW-1:0] uc;
  logic [CW-1:0] vc;
  logic [CW-1:0] ax;
  logic [CW-1:0] ay;
  logic [CW-1:0] dsum;

  always_comb begin
    u5   = {1'b0, u, 2'b00} + {3'b000, u};
    v5   = {1'b0, v, 2'b00} + {3'b000, v};
    uc   = CW'(u);
    vc   = CW'(v);
    ax   = CW'(u5 >> 1) + cfg.ts_x;
    ay   = CW'(v5 >> 1) + cfg.ts_y;
    dsum = uc * CW'(11) + vc * CW'(15) + cfg.ts_diag;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < OCTAVES; i++) begin
        fog_x[i] <= ax << i;
        fog_y[i] <= ay << i;
      end
      grain_x  <= uc * CW'(28) + cfg.dx5;
      grain_y  <= vc * CW'(28) + cfg.dy4;
      stripe_x <= ((uc + vc) << 4) + cfg.ts_stripe;
      stripe_y <= (vc - uc) << 3;
      diag     <= to_q16(dsum[FRAC_BITS-1:0]);
    end
  end

endmodule

// ===== hdl/fnt_vnoise.sv =====
// one lane of 2d hashed value noise, six register stages
// depends on fnt_pkg
module fnt_vnoise (
  input  logic                              clk,
  input  logic                              en,
  input  logic [fnt_pkg::CW-1:0]            x,
  input  logic [fnt_pkg::CW-1:0]            y,
  input  logic [31:0]                       seed_mul,
  output logic [fnt_pkg::NOISE_BITS-1:0]    value
);
  import fnt_pkg::*;

  logic [31:0] mx, my, sm;
  logic [15:0] tx, ty;
  logic [31:0] ttx, tty;
  logic [31:0] m1 [4];
  logic [33:0] px2, py2;
  logic [31:0] m2 [4];
  logic [S_BITS-1:0] sx3, sy3;
  logic [NOISE_BITS-1:0] lat [4];
  logic [S_BITS-1:0] sx4, sy4;
  logic [NOISE_BITS-1:0] top, bot;
  logic [S_BITS-1:0] sy5;

  logic [15:0] tx_n, ty_n;
  logic [31:0] key [4];
  logic [31:0] h0 [4];
  logic [31:0] h1 [4];
  logic [17:0] kx, ky;

  always_comb begin
    tx_n = to_q16(x[FRAC_BITS-1:0]);
    ty_n = to_q16(y[FRAC_BITS-1:0]);
    key[0] = mx + my + sm;
    key[1] = key[0] + HASH_X;
    key[2] = key[0] + HASH_Y;
    key[3] = key[1] + HASH_Y;
    for (int j = 0; j < 4; j++) begin
      h0[j] = key[j] ^ (key[j] >> 16);
      h1[j] = m1[j] ^ (m1[j] >> 15);
    end
    kx = 18'(3 << 16) - {1'b0, tx, 1'b0};
    ky = 18'(3 << 16) - {1'b0, ty, 1'b0};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // cell products and fraction squares
      mx  <= x[FRAC_BITS +: 32] * HASH_X;
      my  <= y[FRAC_BITS +: 32] * HASH_Y;
      sm  <= seed_mul;
      tx  <= tx_n;
      ty  <= ty_n;
      ttx <= 32'(tx_n) * 32'(tx_n);
      tty <= 32'(ty_n) * 32'(ty_n);
      // first hash round, smoothstep product
      for (int j = 0; j < 4; j++) begin
        m1[j] <= h0[j] * MIX_C1;
      end
      px2 <= 34'(ttx[31:16]) * 34'(kx);
      py2 <= 34'(tty[31:16]) * 34'(ky);
      // second hash round
      for (int j = 0; j < 4; j++) begin
        m2[j] <= h1[j] * MIX_C2;
      end
      sx3 <= px2[32:16];
      sy3 <= py2[32:16];
      // lattice values
      for (int j = 0; j < 4; j++) begin
        lat[j] <= NOISE_BITS'(m2[j] ^ (m2[j] >> 16));
      end
      sx4 <= sx3;
      sy4 <= sy3;
      // blends
      top <= blend(lat[0], lat[1], sx4);
      bot <= blend(lat[2], lat[3], sx4);
      sy5 <= sy4;
      value <= blend(top, bot, sy5);
    end
  end

endmodule

// ===== hdl/fnt_mixer.sv =====
// fbm sum, glitch test and weighted channel mix with saturation
// depends on fnt_pkg
module fnt_mixer (
  input  logic                                          clk,
  input  logic                                          en,
  input  logic [fnt_pkg::OCTAVES-1:0][fnt_pkg::NOISE_BITS-1:0] fog,
  input  logic [fnt_pkg::NOISE_BITS-1:0]                grain,
  input  logic [fnt_pkg::NOISE_BITS-1:0]                stripe,
  input  logic [15:0]                                   diag,
  output logic [fnt_pkg::COLOR_BITS-1:0]                red,
  output logic [fnt_pkg::COLOR_BITS-1:0]                green,
  output logic [fnt_pkg::COLOR_BITS-1:0]                blue
);
  import fnt_pkg::*;

  logic [NOISE_BITS:0]     fog_sum;
  logic [NOISE_BITS:0]     fog_r;
  logic [NOISE_BITS-1:0]   grain_r;
  logic                    glitch_r;
  logic [ACC_W-1:0]        acc [3];
  logic [COLOR_BITS-1:0]   chan [3];
  logic [ACC_W-1:0]        acc_next [3];
  logic [COLOR_BITS-1:0]   chan_next [3];
  logic [47:0]             scaled [3];

  always_comb begin
    fog_sum = '0;
    for (int i = 0; i < OCTAVES; i++) begin
      fog_sum = fog_sum + ((NOISE_BITS+1)'(fog[i]) >> (i + 1));
    end
    for (int c = 0; c < 3; c++) begin
      acc_next[c] = (ACC_W'(CH_BASE[c]) << 24)
                  + ACC_W'(CH_FOG[c]) * ACC_W'(fog_r)
                  + ACC_W'(CH_GRAIN[c]) * ACC_W'(grain_r)
                  + (glitch_r ? (ACC_W'(CH_GLITCH[c]) << 24) : ACC_W'(0));
      scaled[c] = {acc[c][39:0], 8'b0} - 48'(acc[c][39:0]);
      if (|acc[c][ACC_W-1:40]) begin
        chan_next[c] = '1;
      end else begin
        chan_next[c] = scaled[c][47:40];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fog_r    <= fog_sum;
      grain_r  <= grain;
      glitch_r <= (stripe > GLITCH_LEVEL) && (diag > DIAG_LO) && (diag < DIAG_HI);
      for (int c = 0; c < 3; c++) begin
        acc[c]  <= acc_next[c];
        chan[c] <= chan_next[c];
      end
    end
  end

  assign red   = chan[0];
  assign green = chan[1];
  assign blue  = chan[2];

endmodule

// ===== hdl/fog_noise_texel_rgb.sv =====
// from pixel transfer a pixel passes 7 divider stages, 1 coordinate stage, 6 noise stages and 3 mix stages
// before texel_valid; throughput one texel per cycle unless texel_stall or cfg_busy holds it
// the whole pipeline holds while texel_stall is high and a texel waits at the output
// pixel_stall is also high for the cycle after reset and after each register write,
// while derived config values start to settle (seed and time products are registered before cfg)
// reset empties the pipeline and sets width 256, height 256, seed 0, time 0
`include "fog_noise_texel_rgb_macros.svh"
module fog_noise_texel_rgb (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  pixel_valid,
  output logic                                  pixel_stall,
  input  logic [fnt_pkg::COORD_BITS-1:0]        pixel_x,
  input  logic [fnt_pkg::COORD_BITS-1:0]        pixel_y,
  output logic                                  texel_valid,
  input  logic                                  texel_stall,
  output logic [fnt_pkg::COLOR_BITS-1:0]        red,
  output logic [fnt_pkg::COLOR_BITS-1:0]        green,
  output logic [fnt_pkg::COLOR_BITS-1:0]        blue,
  input  logic                                  cfg_write,
  input  logic [fnt_pkg::CFG_IDX_BITS-1:0]      cfg_index,
  input  logic [fnt_pkg::DATA_BITS-1:0]         cfg_data
);
  import fnt_pkg::*;

  cfg_t cfg;
  logic en;
  logic cfg_busy;
  logic [PIPE_LAT-1:0] vld;
  logic [QW-1:0] u, v;
  logic [OCTAVES-1:0][CW-1:0] fog_x, fog_y;
  logic [CW-1:0] grain_x, grain_y, stripe_x, stripe_y;
  logic [15:0] diag;
  logic [15:0] diag_d [NV_LAT];
  logic [OCTAVES-1:0][NOISE_BITS-1:0] fog_n;
  logic [NOISE_BITS-1:0] grain_n, stripe_val;

  assign en          = !(texel_valid && texel_stall);
  assign pixel_stall = !en || cfg_busy;
  assign texel_valid = vld[PIPE_LAT-1];

  // hold off pixels after reset and each register write, while derived config values start to settle
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_busy <= 1'b1;
    end else begin
      cfg_busy <= cfg_write;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[PIPE_LAT-2:0], pixel_valid && !cfg_busy};
    end
  end

  fnt_config u_config (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  fnt_divider u_div_x (
    .clk      (clk),
    .en       (en),
    .dividend ({pixel_x, {FRAC_BITS{1'b0}}}),
    .divisor  (cfg.width),
    .quotient (u)
  );

  fnt_divider u_div_y (
    .clk      (clk),
    .en       (en),
    .dividend ({pixel_y, {FRAC_BITS{1'b0}}}),
    .divisor  (cfg.height),
    .quotient (v)
  );

  fnt_coords u_coords (
    .clk      (clk),
    .en       (en),
    .u        (u),
    .v        (v),
    .cfg      (cfg),
    .fog_x    (fog_x),
    .fog_y    (fog_y),
    .grain_x  (grain_x),
    .grain_y  (grain_y),
    .stripe_x (stripe_x),
    .stripe_y (stripe_y),
    .diag     (diag)
  );

  for (genvar i = 0; i < OCTAVES; i++) begin : g_fog
    fnt_vnoise u_fog (
      .clk      (clk),
      .en       (en),
      .x        (fog_x[i]),
      .y        (fog_y[i]),
      .seed_mul (cfg.sdp_fog[i]),
      .value    (fog_n[i])
    );
  end

  fnt_vnoise u_grain (
    .clk      (clk),
    .en       (en),
    .x        (grain_x),
    .y        (grain_y),
    .seed_mul (cfg.sdp_grain),
    .value    (grain_n)
  );

  fnt_vnoise u_stripe (
    .clk      (clk),
    .en       (en),
    .x        (stripe_x),
    .y        (stripe_y),
    .seed_mul (cfg.sdp_stripe),
    .value    (stripe_val)
  );

  // diagonal fraction travels alongside the noise lanes
  always_ff @(posedge clk) begin
    if (en) begin
      diag_d[0] <= diag;
      for (int i = 1; i < NV_LAT; i++) begin
        diag_d[i] <= diag_d[i-1];
      end
    end
  end

  fnt_mixer u_mixer (
    .clk    (clk),
    .en     (en),
    .fog    (fog_n),
    .grain  (grain_n),
    .stripe (stripe_val),
    .diag   (diag_d[NV_LAT-1]),
    .red    (red),
    .green  (green),
    .blue   (blue)
  );

  `FNT_ASSERT_NOW(a_ready_when_out_empty, !texel_valid && !cfg_busy, !pixel_stall)
  `FNT_ASSERT_NEXT(a_pipe_frozen, !rst && texel_valid && texel_stall, vld == $past(vld))
  `FNT_ASSERT_NEXT(a_pipe_entry, !rst && !pixel_stall, vld[0] == $past(pixel_valid))

endmodule
